FILE: hdl/rpfb_pkg.sv
package rpfb_pkg;

  localparam int DEF_DISPLAY_WIDTH  = 128;
  localparam int DEF_DISPLAY_HEIGHT = 64;
  localparam int DEF_LEFT_MARGIN    = 0;
  localparam int DEF_RIGHT_LIMIT    = 128;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_SET_PIXEL   = 3'd0,
    OP_CLEAR_PIXEL = 3'd1,
    OP_HSPAN       = 3'd2,
    OP_VSPAN       = 3'd3,
    OP_TOP_BAR     = 3'd4,
    OP_CLEAR_ALL   = 3'd5,
    OP_READ_BYTE   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    K_DRAW,
    K_CLEAR,
    K_READ
  } cmd_kind_t;

  // drawing commands are rectangles of logical points, inner loop over y
  typedef struct packed {
    cmd_kind_t   kind;
    logic        clr;
    logic [15:0] x_lo;
    logic [15:0] x_hi;
    logic [15:0] y_lo;
    logic [15:0] y_hi;
    logic [15:0] rd_addr;
    logic        rd_ok;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] idx;
    logic [7:0]  mask;
  } loc_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_WRITE,
    ST_READ,
    ST_RESULT
  } state_t;

  // rotate, shift by margin, clip, and find byte index and bit mask
  function automatic loc_t locate(input logic [15:0] x, input logic [15:0] y,
                                  input int w, input int h, input int lm, input int rl);
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] lx;
    logic [31:0] pos;
    loc_t        r;
    row    = 16'(h - 1) - x;
    col    = 16'(w - 1) - y;
    lx     = col + 16'(lm);
    r.hit  = ({16'd0, lx} < 32'(w)) && ({16'd0, lx} < 32'(rl)) && ({16'd0, row} < 32'(h));
    pos    = {19'd0, row[15:3]} * 32'(w) + {16'd0, lx};
    r.idx  = pos[15:0];
    r.mask = 8'd1 << row[2:0];
    return r;
  endfunction

endpackage

FILE: hdl/rpfb_front.sv
module rpfb_front #(
  parameter int DISPLAY_WIDTH  = rpfb_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = rpfb_pkg::DEF_DISPLAY_HEIGHT,
  parameter int LEFT_MARGIN    = rpfb_pkg::DEF_LEFT_MARGIN,
  parameter int RIGHT_LIMIT    = rpfb_pkg::DEF_RIGHT_LIMIT
) (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     operation,
  input  logic [15:0]    pos_x,
  input  logic [15:0]    pos_y,
  input  logic [15:0]    x_end,
  input  logic [15:0]    y_end,
  input  logic [7:0]     bar_height,
  input  logic [9:0]     read_index,
  input  logic           q_ready,
  input  logic           init_busy,
  output logic           push,
  output rpfb_pkg::cmd_t cmd
);
  import rpfb_pkg::*;

  localparam int VIS_COLS    = (RIGHT_LIMIT < DISPLAY_WIDTH) ? RIGHT_LIMIT : DISPLAY_WIDTH;
  localparam int BAR_COLS    = (RIGHT_LIMIT < DISPLAY_HEIGHT) ? RIGHT_LIMIT : DISPLAY_HEIGHT;
  localparam int STORE_BYTES = ((DISPLAY_HEIGHT + 7) / 8) * DISPLAY_WIDTH;

  localparam logic [15:0] H_LAST   = 16'(DISPLAY_HEIGHT - 1);
  localparam logic [15:0] VY_LO    = 16'(LEFT_MARGIN + DISPLAY_WIDTH - VIS_COLS);
  localparam logic [15:0] VY_HI    = 16'(LEFT_MARGIN + DISPLAY_WIDTH - 1);
  localparam logic [15:0] BAR_X_HI = 16'(BAR_COLS - 1);

  logic [15:0] hx_hi;
  logic [15:0] vy_lo;
  logic [15:0] vy_hi;
  logic        drop;

  always_comb begin
    hx_hi = (x_end < H_LAST) ? x_end : H_LAST;
    vy_lo = (pos_y > VY_LO) ? pos_y : VY_LO;
    vy_hi = (y_end < VY_HI) ? y_end : VY_HI;

    cmd         = '0;
    cmd.kind    = K_DRAW;
    cmd.clr     = 1'b0;
    cmd.x_lo    = pos_x;
    cmd.x_hi    = pos_x;
    cmd.y_lo    = pos_y;
    cmd.y_hi    = pos_y;
    cmd.rd_addr = 16'(read_index);
    cmd.rd_ok   = 32'(read_index) < 32'(STORE_BYTES);
    drop        = 1'b0;

    unique case (op_t'(operation))
      OP_SET_PIXEL: begin
        cmd.clr = 1'b0;
      end
      OP_CLEAR_PIXEL: begin
        cmd.clr = 1'b1;
      end
      OP_HSPAN: begin
        cmd.x_hi = hx_hi;
        drop     = pos_x > hx_hi;
      end
      OP_VSPAN: begin
        cmd.y_lo = vy_lo;
        cmd.y_hi = vy_hi;
        drop     = vy_lo > vy_hi;
      end
      OP_TOP_BAR: begin
        cmd.x_lo = 16'd0;
        cmd.x_hi = BAR_X_HI;
        cmd.y_lo = 16'd0;
        cmd.y_hi = 16'(bar_height) - 16'd1;
        drop     = bar_height == 8'd0;
      end
      OP_CLEAR_ALL: begin
        cmd.kind = K_CLEAR;
      end
      OP_READ_BYTE: begin
        cmd.kind = K_READ;
      end
      default: begin
        drop = 1'b1;
      end
    endcase

    in_ready = q_ready && !init_busy;
    push     = in_valid && in_ready && !drop;
  end

endmodule

FILE: hdl/rpfb_queue.sv
module rpfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rpfb_pkg::cmd_t push_cmd,
  output logic           not_full,
  input  logic           pop,
  output rpfb_pkg::cmd_t head,
  output logic           not_empty
);
  import rpfb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = count != CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/rpfb_back.sv
module rpfb_back #(
  parameter int DISPLAY_WIDTH  = rpfb_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = rpfb_pkg::DEF_DISPLAY_HEIGHT,
  parameter int LEFT_MARGIN    = rpfb_pkg::DEF_LEFT_MARGIN,
  parameter int RIGHT_LIMIT    = rpfb_pkg::DEF_RIGHT_LIMIT
) (
  input  logic           clk,
  input  logic           rst,
  input  rpfb_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           init_busy,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_data
);
  import rpfb_pkg::*;

  localparam int STORE_BYTES = ((DISPLAY_HEIGHT + 7) / 8) * DISPLAY_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_wdata;

  state_t            state;
  state_t            state_next;
  state_t            dispatch;
  cmd_t              cur;
  logic [15:0]       x_cur;
  logic [15:0]       y_cur;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_mask;

  loc_t              loc;
  logic              last_pt;
  logic              last_clr;
  logic              out_free;
  logic              done;
  logic              step;
  logic              load_out;

  always_comb begin
    loc      = locate(x_cur, y_cur, DISPLAY_WIDTH, DISPLAY_HEIGHT, LEFT_MARGIN, RIGHT_LIMIT);
    last_pt  = (x_cur == cur.x_hi) && (y_cur == cur.y_hi);
    last_clr = clr_addr == ADDR_W'(STORE_BYTES - 1);
    out_free = !out_valid || out_ready;
  end

  always_comb begin
    unique case (cmd.kind)
      K_DRAW:  dispatch = ST_SCAN;
      K_CLEAR: dispatch = ST_CLEAR;
      K_READ:  dispatch = ST_READ;
      default: dispatch = ST_IDLE;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (last_clr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = dispatch;
        end
      end
      ST_CLEAR: begin
        if (last_clr) begin
          state_next = cmd_valid ? dispatch : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (loc.hit) begin
          state_next = ST_WRITE;
        end else if (last_pt) begin
          state_next = cmd_valid ? dispatch : ST_IDLE;
        end
      end
      ST_WRITE: begin
        if (last_pt) begin
          state_next = cmd_valid ? dispatch : ST_IDLE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_READ: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = cmd_valid ? dispatch : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = clr_addr;
    mem_raddr = loc.idx[ADDR_W-1:0];
    mem_wdata = 8'd0;
    step      = 1'b0;
    load_out  = 1'b0;
    done      = 1'b0;
    unique case (state)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        done = 1'b0;
      end
      ST_CLEAR: begin
        mem_we = 1'b1;
        done   = last_clr;
      end
      ST_SCAN: begin
        mem_re = loc.hit;
        step   = !loc.hit;
        done   = !loc.hit && last_pt;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr;
        mem_wdata = cur.clr ? (mem_q & ~wr_mask) : (mem_q | wr_mask);
        step      = 1'b1;
        done      = last_pt;
      end
      ST_READ: begin
        mem_re    = cur.rd_ok;
        mem_raddr = cur.rd_addr[ADDR_W-1:0];
      end
      ST_RESULT: begin
        load_out = out_free;
        done     = out_free;
      end
      default: begin
        done = 1'b0;
      end
    endcase
    cmd_pop   = cmd_valid && ((state == ST_IDLE) || done);
    init_busy = state == ST_INIT;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_CLEAR) begin
        clr_addr <= last_clr ? '0 : clr_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur   <= cmd;
      x_cur <= cmd.x_lo;
      y_cur <= cmd.y_lo;
    end else if (step) begin
      if (y_cur == cur.y_hi) begin
        y_cur <= cur.y_lo;
        x_cur <= x_cur + 16'd1;
      end else begin
        y_cur <= y_cur + 16'd1;
      end
    end
    if (state == ST_SCAN && loc.hit) begin
      wr_addr <= loc.idx[ADDR_W-1:0];
      wr_mask <= loc.mask;
    end
    if (load_out) begin
      read_data <= cur.rd_ok ? mem_q : 8'd0;
    end
  end

endmodule

FILE: hdl/rotated_page_framebuffer_draw_core.sv
// throughput: the draw engine visits each point of a pixel, span or top bar in turn, with
//   an extra write step for each visible point; clear all zeroes one store byte per cycle;
//   accepted beats wait in the command queue while the engine is busy
// reset: the store is zeroed by a pass over all ((DISPLAY_HEIGHT+7)/8)*DISPLAY_WIDTH bytes
//   (1024 at the defaults) during which in_ready stays low
module rotated_page_framebuffer_draw_core #(
  parameter int DISPLAY_WIDTH  = rpfb_pkg::DEF_DISPLAY_WIDTH,
  parameter int DISPLAY_HEIGHT = rpfb_pkg::DEF_DISPLAY_HEIGHT,
  parameter int LEFT_MARGIN    = rpfb_pkg::DEF_LEFT_MARGIN,
  parameter int RIGHT_LIMIT    = rpfb_pkg::DEF_RIGHT_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [15:0] x_end,
  input  logic [15:0] y_end,
  input  logic [7:0]  bar_height,
  input  logic [9:0]  read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data
);
  import rpfb_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_not_full;
  logic q_not_empty;
  logic init_busy;

  rpfb_front #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .LEFT_MARGIN   (LEFT_MARGIN),
    .RIGHT_LIMIT   (RIGHT_LIMIT)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .x_end     (x_end),
    .y_end     (y_end),
    .bar_height(bar_height),
    .read_index(read_index),
    .q_ready   (q_not_full),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  rpfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .not_full (q_not_full),
    .pop      (pop),
    .head     (head),
    .not_empty(q_not_empty)
  );

  rpfb_back #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .LEFT_MARGIN   (LEFT_MARGIN),
    .RIGHT_LIMIT   (RIGHT_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head),
    .cmd_valid(q_not_empty),
    .cmd_pop  (pop),
    .init_busy(init_busy),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data)
  );

`ifndef SYNTH
  a_no_accept_during_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !in_ready)
    else $error("beat accepted while the store is being cleared");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> q_not_full)
    else $error("command queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("command queue underflow");

  a_no_result_during_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !out_valid)
    else $error("result presented during reset clearing");
`endif

endmodule

FILE: sim/rotated_page_framebuffer_draw_core_tb.sv
`timescale 1ns / 1ps

module rotated_page_framebuffer_draw_core_tb;
  import rpfb_pkg::*;

  localparam int DISP_W = DEF_DISPLAY_WIDTH;
  localparam int DISP_H = DEF_DISPLAY_HEIGHT;
  localparam int MARGIN = DEF_LEFT_MARGIN;
  localparam int RLIM = DEF_RIGHT_LIMIT;
  localparam int STORE_BYTES = ((DISP_H + 7) / 8) * DISP_W;
  localparam int SPAN_LIM = (DISP_W < RLIM) ? DISP_W : RLIM;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 925;
  localparam int QUIET_TAIL = 150;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  operation;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] x_end;
  logic [15:0] y_end;
  logic [7:0]  bar_height;
  logic [9:0]  read_index;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  read_data;

  bit idle_on;
  int cycle_count;

  class framebuffer_shadow;
    bit [7:0] frame [STORE_BYTES];
    bit [7:0] pending_reads [$];
    int errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (frame[i]) frame[i] = 8'h00;
    endfunction

    // rotate, apply margin and clip; false when the point is off screen
    function bit pixel_spot(input bit [15:0] x, input bit [15:0] y, output int idx,
                            output bit [7:0] bit_mask);
      bit [15:0] row;
      bit [15:0] col;
      bit [15:0] lx;
      row = 16'(DISP_H - 1) - x;
      col = 16'(DISP_W - 1) - y;
      lx = col + 16'(MARGIN);
      idx = 0;
      bit_mask = 8'h00;
      if (int'(lx) >= DISP_W || int'(lx) >= RLIM || int'(row) >= DISP_H) return 1'b0;
      idx = int'(row >> 3) * DISP_W + int'(lx);
      if (idx >= STORE_BYTES) return 1'b0;
      bit_mask = 8'd1 << row[2:0];
      return 1'b1;
    endfunction

    function void paint(input bit [15:0] x, input bit [15:0] y, input bit on);
      int idx;
      bit [7:0] bit_mask;
      if (!pixel_spot(x, y, idx, bit_mask)) return;
      if (on) frame[idx] = frame[idx] | bit_mask;
      else frame[idx] = frame[idx] & ~bit_mask;
    endfunction

    function void apply_command(input logic [2:0] op, input bit [15:0] px, input bit [15:0] py,
                                input bit [15:0] xe, input bit [15:0] ye, input bit [7:0] bh,
                                input bit [9:0] ri);
      bit [15:0] v;
      case (op)
        OP_SET_PIXEL: paint(px, py, 1'b1);
        OP_CLEAR_PIXEL: paint(px, py, 1'b0);
        OP_HSPAN: begin
          for (int r = 0; r < DISP_H; r++) begin
            v = 16'(DISP_H - 1 - r);
            if (v >= px && v <= xe) paint(v, py, 1'b1);
          end
        end
        OP_VSPAN: begin
          for (int c = 0; c < SPAN_LIM; c++) begin
            v = 16'(DISP_W - 1 + MARGIN - c);
            if (v >= py && v <= ye) paint(px, v, 1'b1);
          end
        end
        OP_TOP_BAR: begin
          for (int x = 0; x < RLIM; x++)
            for (int y = 0; y < int'(bh); y++) paint(16'(x), 16'(y), 1'b1);
        end
        OP_CLEAR_ALL: wipe();
        OP_READ_BYTE: pending_reads.push_back((int'(ri) < STORE_BYTES) ? frame[ri] : 8'h00);
        default: ;
      endcase
    endfunction

    function void check_read_data(input bit [7:0] got);
      bit [7:0] want;
      if (pending_reads.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected read_data beat %02h", got);
        return;
      end
      want = pending_reads.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("read_data mismatch: expected %02h, got %02h", want, got);
      end
    endfunction
  endclass

  framebuffer_shadow shadow;

  rotated_page_framebuffer_draw_core #(
    .DISPLAY_WIDTH(DISP_W),
    .DISPLAY_HEIGHT(DISP_H),
    .LEFT_MARGIN(MARGIN),
    .RIGHT_LIMIT(RLIM)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .x_end(x_end),
    .y_end(y_end),
    .bar_height(bar_height),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: check every accepted beat, stall in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) shadow.check_read_data(read_data);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 9);
      out_ready <= (stall_left == 0);
    end
  end

  task automatic send_cmd(input logic [2:0] op, input logic [15:0] px, input logic [15:0] py,
                          input logic [15:0] xe, input logic [15:0] ye, input logic [7:0] bh,
                          input logic [9:0] ri);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    pos_x <= px;
    pos_y <= py;
    x_end <= xe;
    y_end <= ye;
    bar_height <= bh;
    read_index <= ri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.apply_command(op, px, py, xe, ye, bh, ri);
  endtask

  task automatic drain_reads();
    in_valid <= 1'b0;
    while (shadow.pending_reads.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] near_x();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
  endfunction

  function automatic logic [15:0] near_y();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 135));
  endfunction

  task automatic send_random();
    logic [2:0]  op;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] xe;
    logic [15:0] ye;
    logic [7:0]  bh;
    int pick;
    pick = $urandom_range(0, 99);
    px = near_x();
    py = near_y();
    xe = 16'($urandom);
    ye = 16'($urandom);
    bh = 8'($urandom);
    if (pick < 26) op = OP_SET_PIXEL;
    else if (pick < 38) op = OP_CLEAR_PIXEL;
    else if (pick < 50) begin
      op = OP_HSPAN;
      if ($urandom_range(0, 7) != 0) xe = ($urandom_range(0, 5) == 0) ? 16'hffff : near_x();
    end else if (pick < 62) begin
      op = OP_VSPAN;
      if ($urandom_range(0, 7) != 0) ye = ($urandom_range(0, 5) == 0) ? 16'hffff : near_y();
    end else if (pick < 66) begin
      op = OP_TOP_BAR;
      bh = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
    end else if (pick < 69) op = OP_CLEAR_ALL;
    else if (pick < 98) op = OP_READ_BYTE;
    else op = OP_UNUSED;
    send_cmd(op, px, py, xe, ye, bh, 10'($urandom));
  endtask

  initial begin
    int done;
    shadow = new();
    cycle_count = 0;
    idle_on = 1'b1;
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_SET_PIXEL;
    pos_x <= '0;
    pos_y <= '0;
    x_end <= '0;
    y_end <= '0;
    bar_height <= '0;
    read_index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // corners, clipping, span ends, bar extremes, clear and the unused code
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd1023);
    send_cmd(OP_SET_PIXEL, 16'd0, 16'd0, 16'hffff, 16'hffff, 8'hff, 10'd0);
    send_cmd(OP_SET_PIXEL, 16'd63, 16'd127, 16'h0000, 16'h0000, 8'h00, 10'd1023);
    send_cmd(OP_SET_PIXEL, 16'd64, 16'd0, 16'h5555, 16'haaaa, 8'h55, 10'h155);
    send_cmd(OP_SET_PIXEL, 16'd0, 16'd128, 16'haaaa, 16'h5555, 8'haa, 10'h2aa);
    send_cmd(OP_SET_PIXEL, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 8'h00, 10'd0);
    send_cmd(OP_READ_BYTE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 10'd1023);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd0);
    send_cmd(OP_CLEAR_PIXEL, 16'd0, 16'd0, 16'h0000, 16'h0000, 8'h00, 10'd0);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd1023);
    send_cmd(OP_HSPAN, 16'd0, 16'd5, 16'hffff, 16'h0000, 8'h00, 10'd0);
    send_cmd(OP_HSPAN, 16'd10, 16'd6, 16'd3, 16'h0000, 8'h00, 10'd0);
    send_cmd(OP_VSPAN, 16'd7, 16'd0, 16'h0000, 16'hffff, 8'h00, 10'd0);
    send_cmd(OP_VSPAN, 16'd8, 16'd100, 16'h0000, 16'd20, 8'h00, 10'd0);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd122);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd1018);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd900);
    send_cmd(OP_TOP_BAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 10'd0);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd512);
    send_cmd(OP_TOP_BAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd255, 10'd0);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd300);
    send_cmd(OP_CLEAR_ALL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd0);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd1023);
    send_cmd(OP_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 10'h3ff);
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'd0);
    drain_reads();

    for (done = 0; done < RANDOM_ITEMS; done++) begin
      if (done == 300 || done == 600) drain_reads();
      if (done == RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      send_random();
    end
    send_cmd(OP_READ_BYTE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 10'($urandom));
    drain_reads();
    repeat (20) @(posedge clk);

    if (shadow.errors == 0 && shadow.pending_reads.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
